>>> hdl/imd_pkg.sv
// ----------------------------------------------------------------------------
// imd_pkg: shared types and helpers for the integer matrix determinant
// Sizes, the control word between the sequencer and the multiply-accumulate
// unit, and the permutation helpers used to walk the Leibniz terms.
// ----------------------------------------------------------------------------
`default_nettype none

package imd_pkg;

  localparam int MAX_SIZE = 4;
  localparam int DATA_W   = 32;
  localparam int CFG_W    = 3;
  localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
  localparam int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(3);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [SIZE_W-1:0]        size_t;
  typedef logic [CFG_W-1:0]         cfg_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef idx_t [MAX_SIZE-1:0]      perm_t;

  typedef enum logic {
    ST_LOAD,
    ST_CALC
  } state_t;

  // Control word that travels with each read of the element store.
  typedef struct packed {
    logic valid;
    logic first;      // first factor of a term
    logic last;       // last factor of a term
    logic neg;        // term is subtracted
    logic last_term;  // last factor of the last term
  } dtag_t;

  // Clamp the size register to the supported range.
  function automatic size_t eff_size(cfg_t cfg);
    size_t n;
    if (cfg == '0) begin
      n = size_t'(1);
    end else if (int'(cfg) > MAX_SIZE) begin
      n = size_t'(MAX_SIZE);
    end else begin
      n = size_t'(cfg);
    end
    return n;
  endfunction

  // Each digit e[k] (0..k) selects the transposition of k with k - e[k].
  // Digits above the active size stay zero, so the first n! digit patterns
  // are exactly the permutations of the first n rows.
  function automatic perm_t perm_of(perm_t e);
    perm_t p;
    idx_t  j;
    idx_t  t;
    for (int i = 0; i < MAX_SIZE; i++) p[i] = idx_t'(i);
    for (int k = 1; k < MAX_SIZE; k++) begin
      j    = idx_t'(k) - e[k];
      t    = p[k];
      p[k] = p[j];
      p[j] = t;
    end
    return p;
  endfunction

  function automatic perm_t digits_inc(perm_t e, size_t n);
    perm_t r;
    logic  carry;
    r     = e;
    carry = 1'b1;
    for (int k = 1; k < MAX_SIZE; k++) begin
      if (carry && (k < int'(n))) begin
        if (r[k] == idx_t'(k)) begin
          r[k] = '0;
        end else begin
          r[k]  = r[k] + idx_t'(1);
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic logic digits_done(perm_t e, size_t n);
    logic done;
    done = 1'b1;
    for (int k = 1; k < MAX_SIZE; k++) begin
      if ((k < int'(n)) && (e[k] != idx_t'(k))) done = 1'b0;
    end
    return done;
  endfunction

  function automatic logic digits_odd(perm_t e);
    logic odd;
    odd = 1'b0;
    for (int k = 1; k < MAX_SIZE; k++) odd = odd ^ (e[k] != '0);
    return odd;
  endfunction

endpackage

`default_nettype wire

>>> hdl/imd_store.sv
// ----------------------------------------------------------------------------
// imd_store: element memory
// One write port for loading, one registered read port for the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module imd_store (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire imd_pkg::addr_t waddr,
  input  wire imd_pkg::data_t wdata,
  input  wire imd_pkg::addr_t raddr,
  output imd_pkg::data_t      rdata
);
  import imd_pkg::*;

  data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/imd_seq.sv
// ----------------------------------------------------------------------------
// imd_seq: term sequencer
// Walks every permutation of the active rows and, for each, every column,
// issuing one store address per cycle with a control word for the MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module imd_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire imd_pkg::size_t n,
  output imd_pkg::addr_t      raddr,
  output imd_pkg::dtag_t      tag,
  output logic                busy
);
  import imd_pkg::*;

  logic  running;
  idx_t  col;
  perm_t digits;
  perm_t perm;
  idx_t  row;
  logic  last_col;
  logic  last_perm;

  always_comb begin
    perm      = perm_of(digits);
    row       = perm[col];
    last_col  = (col == idx_t'(n - size_t'(1)));
    last_perm = digits_done(digits, n);
    raddr     = addr_t'(addr_t'(row) * addr_t'(n) + addr_t'(col));
    tag.valid     = running;
    tag.first     = (col == '0);
    tag.last      = last_col;
    tag.neg       = digits_odd(digits);
    tag.last_term = last_col && last_perm;
    busy          = running;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      col     <= '0;
      digits  <= '0;
    end else if (start) begin
      running <= 1'b1;
      col     <= '0;
      digits  <= '0;
    end else if (running) begin
      if (last_col) begin
        col    <= '0;
        digits <= digits_inc(digits, n);
        if (last_perm) begin
          running <= 1'b0;
        end
      end else begin
        col <= col + idx_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/imd_mac.sv
// ----------------------------------------------------------------------------
// imd_mac: shared multiply-accumulate unit
// Multiplies the factors of one term into a running product, then adds or
// subtracts the finished product into the determinant accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module imd_mac (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           clear,
  input  wire imd_pkg::data_t rdata,
  input  wire imd_pkg::dtag_t tag,
  output logic                done,
  output imd_pkg::data_t      det
);
  import imd_pkg::*;

  dtag_t tag_q;
  data_t prod;
  data_t acc;
  logic  last_q;
  logic  neg_q;
  logic  fin_q;

  // The tag passes through one register, tag_q, to line up with the registered read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_q  <= '0;
      last_q <= 1'b0;
      neg_q  <= 1'b0;
      fin_q  <= 1'b0;
      done   <= 1'b0;
    end else begin
      tag_q  <= tag;
      last_q <= tag_q.valid && tag_q.last;
      neg_q  <= tag_q.neg;
      fin_q  <= tag_q.valid && tag_q.last_term;
      done   <= last_q && fin_q;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_q.valid) begin
      prod <= tag_q.first ? rdata : data_t'(prod * rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (last_q) begin
      acc <= neg_q ? data_t'(acc - prod) : data_t'(acc + prod);
    end
  end

  assign det = acc;

endmodule

`default_nettype wire

>>> hdl/integer_matrix_determinant.sv
// ----------------------------------------------------------------------------
// integer_matrix_determinant: determinant by the Leibniz permutation sum
// Loads an n x n signed matrix in row-major order and returns its
// determinant modulo 2^32 after the last element.
// ----------------------------------------------------------------------------
//  Channel      Signals                                  Dir  Word
//  element      element_valid / element_ready / element   in   one matrix entry
//  determinant  determinant_valid / _ready / determinant   out  one determinant
//  config       size_in_use_write / size_in_use            in   matrix size
//
//  Loading accepts elements back to back. After the last element the sequencer
//  feeds one factor per cycle through the single store read port and the
//  single multiplier. Reset clears control state only; the element store is
//  not cleared. A pending determinant does not stall loading, only the final
//  element.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_matrix_determinant (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           size_in_use_write,
  input  wire imd_pkg::cfg_t  size_in_use,
  input  wire logic           element_valid,
  output logic                element_ready,
  input  wire imd_pkg::data_t element,
  output logic                determinant_valid,
  input  wire logic           determinant_ready,
  output imd_pkg::data_t      determinant
);
  import imd_pkg::*;

  state_t state;
  state_t state_next;
  cfg_t   size_reg;
  size_t  n;
  count_t load_count;
  count_t total;
  logic   last_elem;
  logic   accept;
  logic   start;
  addr_t  raddr;
  data_t  rdata;
  dtag_t  tag;
  logic   seq_busy;
  logic   mac_done;
  data_t  det;

  assign n         = eff_size(size_reg);
  assign total     = count_t'(count_t'(n) * count_t'(n));
  assign last_elem = ((load_count + count_t'(1)) >= total);
  assign accept    = element_valid && element_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && last_elem) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (mac_done) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // The last element waits until the previous determinant has been taken.
  always_comb begin
    element_ready = 1'b0;
    start         = 1'b0;
    unique case (state)
      ST_LOAD: begin
        element_ready = !(determinant_valid && last_elem);
        start         = accept && last_elem;
      end
      ST_CALC: begin
        element_ready = 1'b0;
      end
      default: element_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      size_reg   <= SIZE_RESET;
      load_count <= '0;
    end else begin
      state <= state_next;
      if (size_in_use_write) begin
        size_reg   <= size_in_use;
        load_count <= '0;
      end else if (accept) begin
        load_count <= last_elem ? count_t'(0) : load_count + count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      determinant_valid <= 1'b0;
    end else if (mac_done) begin
      determinant_valid <= 1'b1;
    end else if (determinant_ready) begin
      determinant_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_done) begin
      determinant <= det;
    end
  end

  imd_store u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (load_count[ADDR_W-1:0]),
    .wdata (element),
    .raddr (raddr),
    .rdata (rdata)
  );

  imd_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .n     (n),
    .raddr (raddr),
    .tag   (tag),
    .busy  (seq_busy)
  );

  imd_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .clear (start),
    .rdata (rdata),
    .tag   (tag),
    .done  (mac_done),
    .det   (det)
  );

  a_done_in_calc: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == ST_CALC)
    else $error("determinant finished outside the calculation phase");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> !determinant_valid)
    else $error("determinant finished while the previous word was pending");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> load_count < total)
    else $error("load count reached the matrix size while loading");

  a_seq_starts: assert property (@(posedge clk) disable iff (rst)
    start |=> seq_busy)
    else $error("sequencer did not start after the last element");

  a_busy_in_calc: assert property (@(posedge clk) disable iff (rst)
    seq_busy |-> state == ST_CALC)
    else $error("sequencer running outside the calculation phase");

endmodule

`default_nettype wire
